FILE: hdl/slfp_pkg.sv
package slfp_pkg;

    localparam int SEGMENTS_DEF = 12;

    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 48;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int LEVEL_W = 8;
    localparam int IDX_W = 4;

    // triangle wave timing, all periods divide the common span
    localparam int NORMAL_PERIOD = 2000;
    localparam int SUBTLE_PERIOD = 3000;
    localparam int BREATH_SPAN = 6000;
    localparam int BREATH_LO = 6;
    localparam int SPAN_W = 13;
    localparam int SPAN_Q_W = 20;

    localparam int THIRD_SH = 9;
    localparam int THIRD_RECIP = ((1 << THIRD_SH) + 2) / 3;

    localparam logic [7:0] TOP_RESET = 8'd255;
    localparam logic [15:0] FRESH_RESET = 16'd5000;

    typedef enum logic [3:0] {
        PRES_READY,
        PRES_CHARGING,
        PRES_FULL,
        PRES_BOOTING,
        PRES_WIFI,
        PRES_DEGRADED,
        PRES_CHG_FAULT,
        PRES_CALIBRATING,
        PRES_UPDATING,
        PRES_FAULT
    } pres_t;

    typedef enum logic [1:0] {
        HEALTH_OK,
        HEALTH_BOOTING,
        HEALTH_DEGRADED,
        HEALTH_FAULT
    } health_t;

    typedef enum logic [1:0] {
        BR_STEADY,
        BR_NORMAL,
        BR_SUBTLE
    } br_mode_t;

    typedef enum logic {
        REG_TOP_BRIGHTNESS,
        REG_FRESH_LIMIT
    } reg_idx_t;

    typedef struct packed {
        pres_t        pres;
        logic [7:0]   red;
        logic [7:0]   green;
        logic [7:0]   blue;
        br_mode_t     mode;
        logic [7:0]   level;
        logic         bar;
    } style_t;

    typedef struct packed {
        logic [7:0]  top_brightness;
        logic [15:0] fresh_limit_ms;
    } cfg_t;

    function automatic logic [7:0] top_third(input logic [7:0] top);
        logic [16:0] prod;
        prod = 17'(top) * 17'(THIRD_RECIP);
        return prod[THIRD_SH +: 8];
    endfunction

endpackage

FILE: hdl/slfp_apb_regs.sv
module slfp_apb_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [slfp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [slfp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [slfp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output slfp_pkg::cfg_t                      cfg
);

    slfp_pkg::cfg_t cfg_reg;
    slfp_pkg::cfg_t cfg_next;
    slfp_pkg::reg_idx_t idx;
    logic wr_en;

    assign idx = slfp_pkg::reg_idx_t'(paddr[2]);
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                slfp_pkg::REG_TOP_BRIGHTNESS: cfg_next.top_brightness = pwdata[7:0];
                slfp_pkg::REG_FRESH_LIMIT: cfg_next.fresh_limit_ms = pwdata[15:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            slfp_pkg::REG_TOP_BRIGHTNESS: prdata = 32'(cfg_reg.top_brightness);
            slfp_pkg::REG_FRESH_LIMIT: prdata = 32'(cfg_reg.fresh_limit_ms);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.top_brightness <= slfp_pkg::TOP_RESET;
            cfg_reg.fresh_limit_ms <= slfp_pkg::FRESH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/slfp_front.sv
module slfp_front #(
    parameter int SEGMENTS = slfp_pkg::SEGMENTS_DEF,
    parameter int CW = $clog2(SEGMENTS + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [slfp_pkg::S_DATA_W-1:0]       s_tdata,
    input  slfp_pkg::cfg_t                      cfg,
    output logic                                out_vld,
    input  logic                                out_rdy,
    output slfp_pkg::style_t                    out_style,
    output logic [CW-1:0]                       out_segs,
    output logic [31:0]                         out_now,
    output logic [slfp_pkg::SPAN_Q_W-1:0]       out_q
);

    localparam int BAR_SH = 36;
    localparam longint unsigned BAR_RECIP = ((64'd1 << BAR_SH) + 64'd9999) / 64'd10000;
    localparam longint unsigned BAR_MULT = BAR_RECIP * longint'(SEGMENTS);
    localparam int BAR_PW = 14 + $clog2(BAR_MULT + 1);

    localparam int NOW_SH = 45;
    localparam longint unsigned NOW_RECIP =
        ((64'd1 << NOW_SH) + longint'(slfp_pkg::BREATH_SPAN) - 64'd1) /
        longint'(slfp_pkg::BREATH_SPAN);
    localparam int NOW_PW = 32 + $clog2(NOW_RECIP + 1);

    logic                           in_vld_reg;
    logic [slfp_pkg::S_DATA_W-1:0]  in_data_reg;
    logic                           q_vld_reg;
    slfp_pkg::style_t               style_reg;
    slfp_pkg::style_t               style_next;
    logic [CW-1:0]                  segs_reg;
    logic [CW-1:0]                  segs_next;
    logic [31:0]                    now_reg;
    logic [slfp_pkg::SPAN_Q_W-1:0]  q_reg;
    logic [slfp_pkg::SPAN_Q_W-1:0]  q_next;

    logic                           q_load;
    logic                           in_move;

    slfp_pkg::health_t              health;
    logic                           fw_updating;
    logic                           calibrating;
    logic                           wifi_joining;
    logic                           telemetry_ok;
    logic [31:0]                    tlm_age_ms;
    logic                           soc_finite;
    logic signed [15:0]             soc_centi;
    logic                           batt_charging;
    logic                           batt_alarm;
    logic                           full_verified;
    logic [31:0]                    now_ms;

    logic                           fresh;
    logic                           charge_valid;
    logic                           charging;
    logic                           chg_fault;
    logic                           full;
    slfp_pkg::pres_t                pres;
    logic [BAR_PW-1:0]              bar_prod;
    logic [NOW_PW-1:0]              now_prod;
    logic [7:0]                     top;

    assign q_load = !q_vld_reg || out_rdy;
    assign in_move = in_vld_reg && q_load;
    assign s_tready = !in_vld_reg || q_load;

    assign out_vld = q_vld_reg;
    assign out_style = style_reg;
    assign out_segs = segs_reg;
    assign out_now = now_reg;
    assign out_q = q_reg;

    // word layout
    assign health = slfp_pkg::health_t'(in_data_reg[1:0]);
    assign fw_updating = in_data_reg[2];
    assign calibrating = in_data_reg[3];
    assign wifi_joining = in_data_reg[4];
    assign telemetry_ok = in_data_reg[5];
    assign tlm_age_ms = in_data_reg[37:6];
    assign soc_finite = in_data_reg[38];
    assign soc_centi = signed'(in_data_reg[54:39]);
    assign batt_charging = in_data_reg[55];
    assign batt_alarm = in_data_reg[56];
    assign full_verified = in_data_reg[57];
    assign now_ms = in_data_reg[89:58];

    assign top = cfg.top_brightness;

    always_comb begin
        fresh = telemetry_ok && (tlm_age_ms <= 32'(cfg.fresh_limit_ms));
        charge_valid = fresh && soc_finite;
        charging = fresh && batt_charging;
        chg_fault = charging && batt_alarm;
        full = fresh && !batt_alarm && full_verified;

        if (health == slfp_pkg::HEALTH_FAULT) begin
            pres = slfp_pkg::PRES_FAULT;
        end else if (fw_updating) begin
            pres = slfp_pkg::PRES_UPDATING;
        end else if (calibrating) begin
            pres = slfp_pkg::PRES_CALIBRATING;
        end else if (chg_fault) begin
            pres = slfp_pkg::PRES_CHG_FAULT;
        end else if (health == slfp_pkg::HEALTH_DEGRADED) begin
            pres = slfp_pkg::PRES_DEGRADED;
        end else if (wifi_joining) begin
            pres = slfp_pkg::PRES_WIFI;
        end else if (health == slfp_pkg::HEALTH_BOOTING) begin
            pres = slfp_pkg::PRES_BOOTING;
        end else if (full) begin
            pres = slfp_pkg::PRES_FULL;
        end else if (charging) begin
            pres = slfp_pkg::PRES_CHARGING;
        end else begin
            pres = slfp_pkg::PRES_READY;
        end
    end

    always_comb begin
        style_next = '0;
        style_next.pres = pres;
        style_next.mode = slfp_pkg::BR_STEADY;
        case (pres)
            slfp_pkg::PRES_FAULT: begin
                style_next.red = 8'd255;
                style_next.level = top;
            end
            slfp_pkg::PRES_UPDATING: begin
                style_next.green = 8'd80;
                style_next.blue = 8'd255;
                style_next.mode = slfp_pkg::BR_NORMAL;
            end
            slfp_pkg::PRES_CALIBRATING: begin
                style_next.red = 8'd160;
                style_next.blue = 8'd220;
                style_next.mode = slfp_pkg::BR_NORMAL;
            end
            slfp_pkg::PRES_CHG_FAULT: begin
                style_next.red = 8'd255;
                style_next.mode = slfp_pkg::BR_NORMAL;
            end
            slfp_pkg::PRES_DEGRADED: begin
                style_next.red = 8'd255;
                style_next.green = 8'd140;
                style_next.level = top >> 1;
            end
            slfp_pkg::PRES_WIFI: begin
                style_next.green = 8'd200;
                style_next.blue = 8'd200;
                style_next.mode = slfp_pkg::BR_NORMAL;
            end
            slfp_pkg::PRES_BOOTING: begin
                style_next.red = 8'd255;
                style_next.green = 8'd255;
                style_next.blue = 8'd255;
                style_next.mode = slfp_pkg::BR_SUBTLE;
            end
            slfp_pkg::PRES_FULL: begin
                style_next.green = 8'd255;
                style_next.mode = slfp_pkg::BR_SUBTLE;
            end
            default: begin
                if (!charge_valid) begin
                    style_next.red = 8'd255;
                    style_next.green = 8'd140;
                    style_next.mode = slfp_pkg::BR_SUBTLE;
                end else begin
                    style_next.bar = 1'b1;
                    style_next.level = slfp_pkg::top_third(top);
                end
            end
        endcase
    end

    // exact reciprocal multiply for the bar count and the breathing span
    always_comb begin
        bar_prod = BAR_PW'(soc_centi[13:0]) * BAR_PW'(BAR_MULT);
        if (!charge_valid || soc_centi <= 16'sd0) begin
            segs_next = '0;
        end else if (soc_centi >= 16'sd10000) begin
            segs_next = CW'(SEGMENTS);
        end else begin
            segs_next = bar_prod[BAR_SH +: CW];
        end
        now_prod = NOW_PW'(now_ms) * NOW_PW'(NOW_RECIP);
        q_next = now_prod[NOW_SH +: slfp_pkg::SPAN_Q_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (q_load) begin
                q_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (in_move) begin
            style_reg <= style_next;
            segs_reg <= segs_next;
            now_reg <= now_ms;
            q_reg <= q_next;
        end
    end

endmodule

FILE: hdl/slfp_breathe.sv
module slfp_breathe #(
    parameter int CW = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [7:0]                          top,
    input  logic                                in_vld,
    output logic                                in_rdy,
    input  slfp_pkg::style_t                    in_style,
    input  logic [CW-1:0]                       in_segs,
    input  logic [31:0]                         in_now,
    input  logic [slfp_pkg::SPAN_Q_W-1:0]       in_q,
    output logic                                out_vld,
    input  logic                                out_rdy,
    output slfp_pkg::style_t                    out_style,
    output logic [CW-1:0]                       out_segs,
    output logic [7:0]                          out_br_norm,
    output logic [7:0]                          out_br_sub
);

    localparam int P_W = 18;
    localparam int DIV_SH = 28;
    localparam int H_NORM = slfp_pkg::NORMAL_PERIOD / 2;
    localparam int H_SUB = slfp_pkg::SUBTLE_PERIOD / 2;
    localparam int RECIP_NORM = ((1 << DIV_SH) + H_NORM - 1) / H_NORM;
    localparam int RECIP_SUB = ((1 << DIV_SH) + H_SUB - 1) / H_SUB;
    localparam int D_W = P_W + $clog2(RECIP_NORM + 1);

    logic                           v1_reg;
    logic                           v2_reg;
    logic                           v3_reg;
    slfp_pkg::style_t               st1_reg;
    slfp_pkg::style_t               st2_reg;
    slfp_pkg::style_t               st3_reg;
    logic [CW-1:0]                  sg1_reg;
    logic [CW-1:0]                  sg2_reg;
    logic [CW-1:0]                  sg3_reg;
    logic [slfp_pkg::SPAN_W-1:0]    ph_reg;
    logic [slfp_pkg::SPAN_W-1:0]    ph_next;
    logic [P_W-1:0]                 pn_reg;
    logic [P_W-1:0]                 pn_next;
    logic [P_W-1:0]                 ps_reg;
    logic [P_W-1:0]                 ps_next;
    logic [7:0]                     brn_reg;
    logic [7:0]                     brn_next;
    logic [7:0]                     brs_reg;
    logic [7:0]                     brs_next;

    logic                           ld1;
    logic                           ld2;
    logic                           ld3;
    logic [31:0]                    span_base;
    logic [10:0]                    ph_n;
    logic [11:0]                    ph_s;
    logic [10:0]                    l_n;
    logic [10:0]                    l_s;
    logic [7:0]                     top3;
    logic [7:0]                     rng_n;
    logic [7:0]                     rng_s;
    logic [D_W-1:0]                 dn;
    logic [D_W-1:0]                 ds;

    assign ld3 = !v3_reg || out_rdy;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign in_rdy = ld1;

    assign out_vld = v3_reg;
    assign out_style = st3_reg;
    assign out_segs = sg3_reg;
    assign out_br_norm = brn_reg;
    assign out_br_sub = brs_reg;

    assign top3 = slfp_pkg::top_third(top);

    // time within the common span
    always_comb begin
        span_base = 32'(in_q) * 32'(slfp_pkg::BREATH_SPAN);
        ph_next = slfp_pkg::SPAN_W'(in_now - span_base);
    end

    // phase in each period, folded into the triangle, times the swing
    always_comb begin
        if (ph_reg >= slfp_pkg::SPAN_W'(2 * slfp_pkg::NORMAL_PERIOD)) begin
            ph_n = 11'(ph_reg - slfp_pkg::SPAN_W'(2 * slfp_pkg::NORMAL_PERIOD));
        end else if (ph_reg >= slfp_pkg::SPAN_W'(slfp_pkg::NORMAL_PERIOD)) begin
            ph_n = 11'(ph_reg - slfp_pkg::SPAN_W'(slfp_pkg::NORMAL_PERIOD));
        end else begin
            ph_n = 11'(ph_reg);
        end
        if (ph_reg >= slfp_pkg::SPAN_W'(slfp_pkg::SUBTLE_PERIOD)) begin
            ph_s = 12'(ph_reg - slfp_pkg::SPAN_W'(slfp_pkg::SUBTLE_PERIOD));
        end else begin
            ph_s = 12'(ph_reg);
        end
        l_n = (ph_n <= 11'(H_NORM)) ? ph_n : 11'(slfp_pkg::NORMAL_PERIOD) - ph_n;
        l_s = (ph_s <= 12'(H_SUB)) ? 11'(ph_s) : 11'(12'(slfp_pkg::SUBTLE_PERIOD) - ph_s);
        rng_n = top - 8'(slfp_pkg::BREATH_LO);
        rng_s = top3 - 8'(slfp_pkg::BREATH_LO);
        pn_next = P_W'(l_n) * P_W'(rng_n);
        ps_next = P_W'(l_s) * P_W'(rng_s);
    end

    // divide by the half period
    always_comb begin
        dn = D_W'(pn_reg) * D_W'(RECIP_NORM);
        ds = D_W'(ps_reg) * D_W'(RECIP_SUB);
        if (top <= 8'(slfp_pkg::BREATH_LO)) begin
            brn_next = top;
        end else begin
            brn_next = 8'(slfp_pkg::BREATH_LO) + dn[DIV_SH +: 8];
        end
        if (top3 <= 8'(slfp_pkg::BREATH_LO)) begin
            brs_next = top3;
        end else begin
            brs_next = 8'(slfp_pkg::BREATH_LO) + ds[DIV_SH +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ld1) begin
                v1_reg <= in_vld;
            end
            if (ld2) begin
                v2_reg <= v1_reg;
            end
            if (ld3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1 && in_vld) begin
            st1_reg <= in_style;
            sg1_reg <= in_segs;
            ph_reg <= ph_next;
        end
        if (ld2 && v1_reg) begin
            st2_reg <= st1_reg;
            sg2_reg <= sg1_reg;
            pn_reg <= pn_next;
            ps_reg <= ps_next;
        end
        if (ld3 && v2_reg) begin
            st3_reg <= st2_reg;
            sg3_reg <= sg2_reg;
            brn_reg <= brn_next;
            brs_reg <= brs_next;
        end
    end

endmodule

FILE: hdl/slfp_emit.sv
module slfp_emit #(
    parameter int SEGMENTS = slfp_pkg::SEGMENTS_DEF,
    parameter int CW = $clog2(SEGMENTS + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_vld,
    output logic                                in_rdy,
    input  slfp_pkg::style_t                    in_style,
    input  logic [CW-1:0]                       in_segs,
    input  logic [7:0]                          in_br_norm,
    input  logic [7:0]                          in_br_sub,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [slfp_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);

    localparam int KW = $clog2(SEGMENTS);
    localparam logic [KW-1:0] LAST_SEG = KW'(SEGMENTS - 1);

    logic                           frame_vld_reg;
    slfp_pkg::style_t               frame_style_reg;
    logic [CW-1:0]                  frame_segs_reg;
    logic [7:0]                     frame_br_reg;
    logic [7:0]                     frame_br_next;
    logic [7:0]                     frame_sub_reg;
    logic [KW-1:0]                  seg_cnt_reg;
    logic                           m_vld_reg;
    logic [slfp_pkg::M_DATA_W-1:0]  m_data_reg;
    logic [slfp_pkg::M_DATA_W-1:0]  m_data_next;
    logic                           m_last_reg;

    logic                           out_load;
    logic                           emit_go;
    logic                           frame_done;
    logic                           frame_load;
    logic [CW-1:0]                  seg_pos;
    logic [CW-1:0]                  breathe_pos;
    logic [7:0]                     red;
    logic [7:0]                     green;
    logic [7:0]                     blue;
    logic [7:0]                     level;

    assign out_load = !m_vld_reg || m_tready;
    assign emit_go = frame_vld_reg && out_load;
    assign frame_done = emit_go && (seg_cnt_reg == LAST_SEG);
    assign in_rdy = !frame_vld_reg || frame_done;
    assign frame_load = in_rdy && in_vld;

    assign m_tvalid = m_vld_reg;
    assign m_tdata = m_data_reg;
    assign m_tlast = m_last_reg;

    always_comb begin
        case (in_style.mode)
            slfp_pkg::BR_NORMAL: frame_br_next = in_br_norm;
            slfp_pkg::BR_SUBTLE: frame_br_next = in_br_sub;
            default: frame_br_next = in_style.level;
        endcase
    end

    // result word for the current segment, with the charge bar layout in bar mode
    always_comb begin
        seg_pos = CW'(seg_cnt_reg);
        breathe_pos = (frame_segs_reg < CW'(SEGMENTS)) ? frame_segs_reg : CW'(SEGMENTS - 1);
        red = frame_style_reg.red;
        green = frame_style_reg.green;
        blue = frame_style_reg.blue;
        level = frame_br_reg;
        if (frame_style_reg.bar) begin
            red = 8'd0;
            blue = 8'd0;
            if (seg_pos < frame_segs_reg) begin
                green = 8'd255;
                level = frame_style_reg.level;
            end else begin
                green = 8'd0;
                level = 8'd0;
            end
            if (frame_style_reg.pres == slfp_pkg::PRES_CHARGING && seg_pos == breathe_pos) begin
                green = 8'd255;
                level = frame_sub_reg;
            end
        end
        m_data_next = {4'd0, 4'(frame_segs_reg), frame_style_reg.pres, level, blue, green,
                       red, slfp_pkg::IDX_W'(seg_cnt_reg)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_vld_reg <= 1'b0;
            seg_cnt_reg <= '0;
            m_vld_reg <= 1'b0;
        end else begin
            if (in_rdy) begin
                frame_vld_reg <= in_vld;
            end
            if (emit_go) begin
                seg_cnt_reg <= frame_done ? '0 : seg_cnt_reg + 1'b1;
            end
            if (out_load) begin
                m_vld_reg <= frame_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_load) begin
            frame_style_reg <= in_style;
            frame_segs_reg <= in_segs;
            frame_br_reg <= frame_br_next;
            frame_sub_reg <= in_br_sub;
        end
        if (emit_go) begin
            m_data_reg <= m_data_next;
            m_last_reg <= (seg_cnt_reg == LAST_SEG);
        end
    end

endmodule

FILE: hdl/status_led_frame_policy.sv
// Status LED frame policy. Each accepted update word yields one frame of SEGMENTS result
// words, one per LED segment in logical order, with m_tlast on the final one. The output
// register delivers one result word per cycle while m_tready is high, so for a steady
// stream of updates the segment sequencer is what sets the rate. An update passes the
// input register, decode register, three breathing stages, frame register and output
// register before its first result word, and the next update is taken while the current
// frame is still being sent. Configuration registers: top_brightness at byte address 0,
// fresh_limit_ms at byte address 4; write them only while no frame is in flight.
module status_led_frame_policy #(
    parameter int SEGMENTS = slfp_pkg::SEGMENTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // health[1:0] fw_updating[2] calibrating[3] wifi_joining[4] telemetry_ok[5]
    // tlm_age_ms[37:6] soc_finite[38] soc_centi[54:39] batt_charging[55]
    // batt_alarm[56] full_verified[57] now_ms[89:58]
    input  logic [slfp_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // segment_index[3:0] red[11:4] green[19:12] blue[27:20] brightness[35:28]
    // presentation[39:36] bar_segments[43:40]
    output logic [slfp_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [slfp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [slfp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [slfp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CW = $clog2(SEGMENTS + 1);

    slfp_pkg::cfg_t                 cfg;
    logic                           fr_vld;
    logic                           fr_rdy;
    slfp_pkg::style_t               fr_style;
    logic [CW-1:0]                  fr_segs;
    logic [31:0]                    fr_now;
    logic [slfp_pkg::SPAN_Q_W-1:0]  fr_q;
    logic                           br_vld;
    logic                           br_rdy;
    slfp_pkg::style_t               br_style;
    logic [CW-1:0]                  br_segs;
    logic [7:0]                     br_norm;
    logic [7:0]                     br_sub;

    slfp_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slfp_front #(
        .SEGMENTS (SEGMENTS),
        .CW       (CW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg       (cfg),
        .out_vld   (fr_vld),
        .out_rdy   (fr_rdy),
        .out_style (fr_style),
        .out_segs  (fr_segs),
        .out_now   (fr_now),
        .out_q     (fr_q)
    );

    slfp_breathe #(
        .CW (CW)
    ) u_breathe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .top         (cfg.top_brightness),
        .in_vld      (fr_vld),
        .in_rdy      (fr_rdy),
        .in_style    (fr_style),
        .in_segs     (fr_segs),
        .in_now      (fr_now),
        .in_q        (fr_q),
        .out_vld     (br_vld),
        .out_rdy     (br_rdy),
        .out_style   (br_style),
        .out_segs    (br_segs),
        .out_br_norm (br_norm),
        .out_br_sub  (br_sub)
    );

    slfp_emit #(
        .SEGMENTS (SEGMENTS),
        .CW       (CW)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_vld     (br_vld),
        .in_rdy     (br_rdy),
        .in_style   (br_style),
        .in_segs    (br_segs),
        .in_br_norm (br_norm),
        .in_br_sub  (br_sub),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // last word of a frame carries the final segment position
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[3:0] == 4'(SEGMENTS - 1)))
        else $error("frame end on wrong segment");

    a_top_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite &&
         slfp_pkg::reg_idx_t'(paddr[2]) == slfp_pkg::REG_TOP_BRIGHTNESS)
        |=> (cfg.top_brightness == $past(pwdata[7:0])))
        else $error("top brightness write lost");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

endmodule

FILE: sim/tb_status_led_frame_policy.sv
`timescale 1ns / 1ps

module tb_status_led_frame_policy;

    localparam int SEG_COUNT = slfp_pkg::SEGMENTS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 45;

    // same layout as s_tdata, msb first
    typedef struct packed {
        logic [5:0]         pad;
        logic [31:0]        now_ms;
        logic               full_verified;
        logic               batt_alarm;
        logic               batt_charging;
        logic signed [15:0] soc_centi;
        logic               soc_finite;
        logic [31:0]        tlm_age_ms;
        logic               telemetry_ok;
        logic               wifi_joining;
        logic               calibrating;
        logic               fw_updating;
        slfp_pkg::health_t  health;
    } led_update_t;

    // same layout as m_tdata, msb first
    typedef struct packed {
        logic [3:0]       pad;
        logic [3:0]       bar_segments;
        slfp_pkg::pres_t  pres;
        logic [7:0]       level;
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [3:0]       seg_idx;
    } led_word_t;

    typedef struct {
        led_word_t word;
        logic      tlast_bit;
    } led_expect_t;

    class led_frame_board;
        led_expect_t frame_q[$];
        logic [7:0]  top;
        logic [15:0] fresh_limit;
        int          errors;

        function new();
            top = slfp_pkg::TOP_RESET;
            fresh_limit = slfp_pkg::FRESH_RESET;
            errors = 0;
        endfunction

        function void set_reg(slfp_pkg::reg_idx_t r, logic [31:0] v);
            if (r == slfp_pkg::REG_TOP_BRIGHTNESS) top = v[7:0];
            else fresh_limit = v[15:0];
        endfunction

        function int unsigned breathe_level(int unsigned now, int unsigned period,
                                            int unsigned lo, int unsigned hi);
            int unsigned ph, half, ramp;
            if (hi <= lo) return hi;
            ph = now % period;
            half = period / 2;
            ramp = (ph <= half) ? ph : period - ph;
            return lo + (ramp * (hi - lo)) / half;
        endfunction

        function void note_update(led_update_t u);
            bit fresh, valid, charging, cfault, full, bar_mode;
            int unsigned segs, nxt, r, g, b, lvl, subtle_lvl, normal_lvl;
            int soc;
            slfp_pkg::pres_t pres;
            led_expect_t e;
            fresh = u.telemetry_ok && (u.tlm_age_ms <= {16'd0, fresh_limit});
            valid = fresh && u.soc_finite;
            charging = fresh && u.batt_charging;
            cfault = charging && u.batt_alarm;
            full = fresh && !u.batt_alarm && u.full_verified;
            soc = int'(u.soc_centi);
            if (!valid || soc <= 0) segs = 0;
            else if (soc >= 10000) segs = SEG_COUNT;
            else segs = (soc * SEG_COUNT) / 10000;
            if (u.health == slfp_pkg::HEALTH_FAULT) pres = slfp_pkg::PRES_FAULT;
            else if (u.fw_updating) pres = slfp_pkg::PRES_UPDATING;
            else if (u.calibrating) pres = slfp_pkg::PRES_CALIBRATING;
            else if (cfault) pres = slfp_pkg::PRES_CHG_FAULT;
            else if (u.health == slfp_pkg::HEALTH_DEGRADED) pres = slfp_pkg::PRES_DEGRADED;
            else if (u.wifi_joining) pres = slfp_pkg::PRES_WIFI;
            else if (u.health == slfp_pkg::HEALTH_BOOTING) pres = slfp_pkg::PRES_BOOTING;
            else if (full) pres = slfp_pkg::PRES_FULL;
            else if (charging) pres = slfp_pkg::PRES_CHARGING;
            else pres = slfp_pkg::PRES_READY;
            normal_lvl = breathe_level(u.now_ms, slfp_pkg::NORMAL_PERIOD, slfp_pkg::BREATH_LO,
                                       32'(top));
            subtle_lvl = breathe_level(u.now_ms, slfp_pkg::SUBTLE_PERIOD, slfp_pkg::BREATH_LO,
                                       32'(top) / 3);
            r = 0;
            g = 0;
            b = 0;
            lvl = 0;
            bar_mode = 0;
            case (pres)
                slfp_pkg::PRES_FAULT: begin
                    r = 255; lvl = 32'(top);
                end
                slfp_pkg::PRES_UPDATING: begin
                    g = 80; b = 255; lvl = normal_lvl;
                end
                slfp_pkg::PRES_CALIBRATING: begin
                    r = 160; b = 220; lvl = normal_lvl;
                end
                slfp_pkg::PRES_CHG_FAULT: begin
                    r = 255; lvl = normal_lvl;
                end
                slfp_pkg::PRES_DEGRADED: begin
                    r = 255; g = 140; lvl = 32'(top) / 2;
                end
                slfp_pkg::PRES_WIFI: begin
                    g = 200; b = 200; lvl = normal_lvl;
                end
                slfp_pkg::PRES_BOOTING: begin
                    r = 255; g = 255; b = 255; lvl = subtle_lvl;
                end
                slfp_pkg::PRES_FULL: begin
                    g = 255; lvl = subtle_lvl;
                end
                default: begin
                    if (!valid) begin
                        r = 255; g = 140; lvl = subtle_lvl;
                    end else begin
                        bar_mode = 1;
                    end
                end
            endcase
            nxt = (segs < SEG_COUNT) ? segs : SEG_COUNT - 1;
            for (int k = 0; k < SEG_COUNT; k++) begin
                e.word.pad = '0;
                e.word.seg_idx = 4'(k);
                e.word.pres = pres;
                e.word.bar_segments = 4'(segs);
                e.word.red = 8'(r);
                e.word.green = 8'(g);
                e.word.blue = 8'(b);
                e.word.level = 8'(lvl);
                if (bar_mode) begin
                    e.word.red = 8'd0;
                    e.word.blue = 8'd0;
                    e.word.green = (k < segs) ? 8'd255 : 8'd0;
                    e.word.level = (k < segs) ? 8'(top / 3) : 8'd0;
                    if (pres == slfp_pkg::PRES_CHARGING && k == nxt) begin
                        e.word.green = 8'd255;
                        e.word.level = 8'(subtle_lvl);
                    end
                end
                e.tlast_bit = (k == SEG_COUNT - 1);
                frame_q.push_back(e);
            end
        endfunction

        function void cmp(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_word(logic [slfp_pkg::M_DATA_W-1:0] data, logic tlast_in);
            led_word_t act;
            led_expect_t e;
            act = data;
            if (frame_q.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %h", $time, data);
                errors++;
                return;
            end
            e = frame_q.pop_front();
            cmp("segment_index", 8'(e.word.seg_idx), 8'(act.seg_idx));
            cmp("red", e.word.red, act.red);
            cmp("green", e.word.green, act.green);
            cmp("blue", e.word.blue, act.blue);
            cmp("brightness", e.word.level, act.level);
            cmp("presentation", 8'(e.word.pres), 8'(act.pres));
            cmp("bar_segments", 8'(e.word.bar_segments), 8'(act.bar_segments));
            cmp("tdata padding", 8'(e.word.pad), 8'(act.pad));
            cmp("tlast", 8'(e.tlast_bit), 8'(tlast_in));
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [slfp_pkg::S_DATA_W-1:0]   s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [slfp_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            m_tlast;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [slfp_pkg::CFG_ADDR_W-1:0] paddr;
    logic [slfp_pkg::CFG_DATA_W-1:0] pwdata;
    logic [slfp_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    led_frame_board sb;
    int             send_burst;
    bit             send_quiet;

    status_led_frame_policy dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic led_update_t mk_update(slfp_pkg::health_t h, bit fw, bit cal,
                                              bit wifi, bit tok,
                                              logic [31:0] age, bit fin,
                                              logic signed [15:0] soc, bit chg, bit alarm,
                                              bit fullv, logic [31:0] now);
        led_update_t u;
        u.pad = '0;
        u.health = h;
        u.fw_updating = fw;
        u.calibrating = cal;
        u.wifi_joining = wifi;
        u.telemetry_ok = tok;
        u.tlm_age_ms = age;
        u.soc_finite = fin;
        u.soc_centi = soc;
        u.batt_charging = chg;
        u.batt_alarm = alarm;
        u.full_verified = fullv;
        u.now_ms = now;
        return u;
    endfunction

    // mostly healthy, fresh updates so the charge bar states get most of the traffic
    function automatic led_update_t rand_update();
        led_update_t u;
        int unsigned pick, lim, k, edge_soc;
        lim = 32'(sb.fresh_limit);
        u.pad = '0;
        u.health = ($urandom_range(0, 9) < 6) ? slfp_pkg::HEALTH_OK
                                               : slfp_pkg::health_t'($urandom_range(0, 3));
        u.fw_updating = ($urandom_range(0, 9) == 0);
        u.calibrating = ($urandom_range(0, 9) == 0);
        u.wifi_joining = ($urandom_range(0, 7) == 0);
        u.telemetry_ok = ($urandom_range(0, 19) < 17);
        pick = $urandom_range(0, 9);
        if (pick < 4) u.tlm_age_ms = $urandom_range(0, lim);
        else if (pick < 6) u.tlm_age_ms = (lim < 2) ? $urandom_range(0, 3)
                                                     : lim - 2 + $urandom_range(0, 4);
        else if (pick < 7) u.tlm_age_ms = $urandom();
        else u.tlm_age_ms = $urandom_range(0, 70000);
        u.soc_finite = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            u.soc_centi = 16'($urandom_range(0, 10000));
        end else if (pick < 8) begin
            k = $urandom_range(0, SEG_COUNT);
            edge_soc = (k * 10000 + SEG_COUNT - 1) / SEG_COUNT;
            u.soc_centi = 16'(int'(edge_soc) - 1 + int'($urandom_range(0, 1)));
        end else begin
            u.soc_centi = 16'($urandom());
        end
        u.batt_charging = 1'($urandom_range(0, 1));
        u.batt_alarm = ($urandom_range(0, 6) == 0);
        u.full_verified = ($urandom_range(0, 3) == 0);
        u.now_ms = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 12000) : $urandom();
        return u;
    endfunction

    // starts and ends at a falling edge
    task automatic send_update(led_update_t u);
        int unsigned gap;
        if (send_burst == 0) begin
            send_burst = $urandom_range(8, 30);
            send_quiet = ($urandom_range(0, 2) == 0);
        end
        send_burst--;
        gap = send_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= u;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_update(u);
        @(negedge aclk);
    endtask

    task automatic finish_stream();
        s_tvalid <= 1'b0;
        while (sb.frame_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(slfp_pkg::reg_idx_t r, logic [31:0] v);
        logic [31:0] rd, want;
        want = (r == slfp_pkg::REG_TOP_BRIGHTNESS) ? {24'd0, v[7:0]} : {16'd0, v[15:0]};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= slfp_pkg::CFG_ADDR_W'(int'(r) * 4);
        pwdata <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(r, v);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rd = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== want) begin
            $display("%0t: register %0d readback mismatch, expected %h actual %h",
                     $time, int'(r), want, rd);
            sb.errors++;
        end
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
    end

    initial begin
        int unsigned wait_n;
        int burst;
        bit quiet;
        m_tready = 1'b0;
        burst = 0;
        quiet = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (burst == 0) begin
                burst = $urandom_range(8, 30);
                quiet = ($urandom_range(0, 2) == 0);
            end
            burst--;
            wait_n = quiet ? 0 : $urandom_range(0, 15);
            if (wait_n > 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int unsigned phase_top[PHASE_COUNT];
        int unsigned phase_fresh[PHASE_COUNT];
        int unsigned top_v, fresh_v;
        led_update_t directed_q[$];
        phase_top = '{0, 255, 1, 7, 20, 0, 0, 255};
        phase_fresh = '{0, 65535, 100, 3000, 5000, 0, 0, 5000};
        sb = new();
        send_burst = 0;
        send_quiet = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // every presentation, charge and freshness edges, breathing phase edges
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_FAULT,
                                       1, 1, 1, 1, 0, 1, 5000, 1, 1, 1, 0));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       1, 1, 1, 1, 0, 1, 5000, 1, 1, 0, 500));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 1, 0, 1, 0, 1, 5000, 0, 0, 0, 1000));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_DEGRADED,
                                       0, 0, 1, 1, 0, 1, 5000, 1, 1, 0, 1999));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_DEGRADED,
                                       0, 0, 1, 1, 0, 1, 5000, 0, 0, 1, 7));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_BOOTING,
                                       0, 0, 1, 1, 0, 1, 5000, 1, 0, 1, 2000));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_BOOTING,
                                       0, 0, 0, 1, 0, 1, 5000, 1, 0, 1, 1500));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 5000, 1, 5000, 1, 0, 1, 3000));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 0, 1, 10000, 1, 0, 0, 750));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 0, 1, 0, 1, 0, 0, 1500));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 0, 1, 9999, 1, 0, 0, 2999));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 0, 1, 32767, 0, 0, 0, 100));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 0, 1, -32768, 0, 0, 0, 100));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 0, 1, 833, 1, 0, 0, 200));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 0, 1, 834, 0, 0, 0, 200));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 0, 1, 1, 1, 0, 0, 2250));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 0, 0, 1, 5000, 1, 0, 1, 900));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 5001, 1, 5000, 1, 0, 1, 900));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 0, 0, 5000, 1, 0, 0, 900));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 32'hFFFF_FFFF, 1, 5000, 1, 1,
                                       1, 32'hFFFF_FFFF));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 10, 1, 6000, 0, 1, 1, 1234));
        directed_q.push_back(mk_update(slfp_pkg::HEALTH_OK,
                                       0, 0, 0, 1, 10, 1, 5000, 1, 0, 0, 2999));
        foreach (directed_q[i]) send_update(directed_q[i]);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            finish_stream();
            top_v = phase_top[p];
            fresh_v = phase_fresh[p];
            if (p == 5 || p == 6) begin
                top_v = $urandom_range(0, 255);
                fresh_v = $urandom_range(0, 65535);
            end
            write_reg(slfp_pkg::REG_TOP_BRIGHTNESS,
                      {8'($urandom_range(0, 255)), 16'($urandom()), 8'(top_v)});
            write_reg(slfp_pkg::REG_FRESH_LIMIT, {16'($urandom()), 16'(fresh_v)});
            for (int n = 0; n < PHASE_ITEMS; n++) send_update(rand_update());
        end
        finish_stream();
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/slfp_pkg.sv
hdl/slfp_apb_regs.sv
hdl/slfp_front.sv
hdl/slfp_breathe.sv
hdl/slfp_emit.sv
hdl/status_led_frame_policy.sv
sim/tb_status_led_frame_policy.sv
